@@ hdl/pidaw_pkg.sv @@
package pidaw_pkg;

  // default sizes
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF    = 32;

  // fixed formats
  localparam int GAIN_W    = 16;  // Q8.8 gains
  localparam int CHUNK_W   = 16;  // slice of the wide operand per multiply step
  localparam int PROD_FRAC = 16;  // fraction bits of a gain * Q.8 product
  localparam int DUTY_W    = 7;
  localparam int DUTY_MAX  = 100;

  // register map
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SETPOINT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_WINDUP = 3'd5;

  // which gain/operand pair the shared multiplier works on
  localparam logic [1:0] OP_PROP   = 2'd0;
  localparam logic [1:0] OP_INTEG  = 2'd1;
  localparam logic [1:0] OP_DERIV  = 2'd2;
  localparam logic [1:0] OP_WINDUP = 2'd3;

endpackage

@@ hdl/pid_antiwindup_controller_core.sv @@
// PID temperature loop with back-calculation anti-windup.
//
// Configuration: cfg_we_i/cfg_index_i/cfg_data_i write one register per cycle
// (0 enable, 1 setpoint, 2..5 gains P, I, D, windup); write only while idle.
// Input channel: one beat carries temperature_i and sample_valid_i. A beat with
// the loop disabled or the sample flagged invalid is taken and dropped in the
// same cycle, with no result and no state change.
// Output channel: one beat (duty_o, saturated_o) per used sample.
//
// All four products run through one 16 x 17 bit multiplier, one 16-bit slice
// of the operand per cycle, NCH = ceil((ACC_WIDTH+18)/16) slices per product.
// A used sample keeps in_stall_o high from acceptance until its result enters the
// output register; no new sample is taken while one is in progress.
// A result waiting under out_stall_i does not block the next sample; only
// the final write-back waits for the output register to free.
// Reset (rst_ni low, asynchronous) clears the configuration registers, the stored
// error and the integral, and leaves the output channel empty.
module pid_antiwindup_controller_core #(
  parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = pidaw_pkg::ACC_WIDTH_DEF,
  localparam int CFG_W = (SAMPLE_WIDTH > pidaw_pkg::GAIN_W) ? SAMPLE_WIDTH : pidaw_pkg::GAIN_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidaw_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]                    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      temperature_i,
  input  logic                                sample_valid_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pidaw_pkg::DUTY_W-1:0]        duty_o,
  output logic                                saturated_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int AW    = ACC_WIDTH;
  localparam int GW    = pidaw_pkg::GAIN_W;
  localparam int CH    = pidaw_pkg::CHUNK_W;
  localparam int FR    = pidaw_pkg::PROD_FRAC;
  localparam int DW    = pidaw_pkg::DUTY_W;
  localparam int ERR_W = SW + 1;
  localparam int DER_W = SW + 2;
  localparam int SUM_W = ((ERR_W > AW) ? ERR_W : AW) + 1;
  localparam int XW    = AW + GW + 2;             // windup operand after clamping
  localparam int NCH   = (XW + CH - 1) / CH;
  localparam int XEW   = NCH * CH;
  localparam int PW    = XEW + GW;                // product accumulator
  localparam int RW0   = ((AW + GW > SW + GW + 2) ? AW + GW : SW + GW + 2) + 2;
  localparam int RAW_W = RW0 + 1;                 // raw, and then clamp - raw
  localparam int TS_W  = XEW + 1;
  localparam int CW    = $clog2(NCH);
  localparam int MW    = GW + CH + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_DSAT  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic signed [SUM_W-1:0] IMAX_S = {{(SUM_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] IMIN_S = ~IMAX_S;
  localparam logic signed [TS_W-1:0]  TMAX_S = {{(TS_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [TS_W-1:0]  TMIN_S = ~TMAX_S;
  localparam logic signed [RAW_W-1:0] DMAX_S = {{(RAW_W-XW+1){1'b0}}, {(XW-1){1'b1}}};
  localparam logic signed [RAW_W-1:0] DMIN_S = ~DMAX_S;
  localparam logic signed [RAW_W-1:0] FULL_S = RAW_W'(pidaw_pkg::DUTY_MAX) <<< FR;
  localparam logic signed [RAW_W-1:0] HALF_S = RAW_W'(1) <<< (FR - 1);
  localparam logic [DW-1:0]           DUTY_FULL = DW'(pidaw_pkg::DUTY_MAX);

  // configuration
  logic                    enable_q;
  logic signed [SW-1:0]    setpoint_q;
  logic signed [GW-1:0]    kp_q, ki_q, kd_q, kw_q;

  // loop state
  logic signed [ERR_W-1:0] prev_err_q;
  logic signed [AW-1:0]    integ_q;

  // control
  logic [2:0]              st_q;
  logic [1:0]              op_q;
  logic [CW-1:0]           cnt_q;
  logic                    out_valid_q;

  // datapath
  logic signed [ERR_W-1:0] err_q;
  logic signed [AW-1:0]    erri_q;
  logic signed [DER_W-1:0] errd_q;
  logic signed [XEW-1:0]   x_q;
  logic signed [PW-1:0]    acc_q;
  logic signed [RAW_W-1:0] raw_q;
  logic [DW-1:0]           res_duty_q, out_duty_q;
  logic                    res_sat_q, out_sat_q;

  logic in_take, use_item, out_take, out_free, fin_done;
  assign in_take  = in_valid_i && !in_stall_o;
  assign use_item = in_take && enable_q && sample_valid_i;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_done = (st_q == ST_FIN) && out_free;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign duty_o      = out_duty_q;
  assign saturated_o = out_sat_q;

  // shared multiplier: gain * one operand slice, Horner from the top slice down
  logic signed [GW-1:0] gain_sel;
  logic [CH-1:0]        slice;
  logic                 top_slice;
  logic signed [CH:0]   mul_op;
  logic signed [MW-1:0] mul;
  logic signed [PW-1:0] acc_base, acc_d;

  always_comb begin
    unique case (op_q)
      pidaw_pkg::OP_PROP:  gain_sel = kp_q;
      pidaw_pkg::OP_INTEG: gain_sel = ki_q;
      pidaw_pkg::OP_DERIV: gain_sel = kd_q;
      default:             gain_sel = kw_q;
    endcase
  end

  assign top_slice = (cnt_q == CW'(NCH - 1));
  assign slice     = x_q[cnt_q*CH +: CH];
  assign mul_op    = {top_slice & slice[CH-1], slice};
  assign mul       = gain_sel * mul_op;
  assign acc_base  = top_slice ? '0 : {acc_q[PW-CH-1:0], {CH{1'b0}}};
  assign acc_d     = acc_base + {{(PW-MW){mul[MW-1]}}, mul};

  // integral, saturated before use
  logic signed [SUM_W-1:0] isum;
  logic signed [AW-1:0]    erri_d;
  assign isum = {{(SUM_W-ERR_W){err_q[ERR_W-1]}}, err_q} +
                {{(SUM_W-AW){integ_q[AW-1]}}, integ_q};
  always_comb begin
    priority if (isum > IMAX_S) erri_d = IMAX_S[AW-1:0];
    else if (isum < IMIN_S)     erri_d = IMIN_S[AW-1:0];
    else                        erri_d = isum[AW-1:0];
  end

  // output shaping and anti-windup difference
  logic signed [RAW_W-1:0] scaled, clampv, diff;
  logic [DW-1:0]           duty_d;
  logic                    sat_d;
  assign scaled = raw_q + HALF_S;
  always_comb begin
    priority if (scaled < 0)  duty_d = '0;
    else if (scaled >= FULL_S) duty_d = DUTY_FULL;
    else                       duty_d = scaled[FR +: DW];
  end
  assign sat_d  = (raw_q < 0) || (raw_q > FULL_S);
  assign clampv = (raw_q < 0) ? '0 : ((raw_q > FULL_S) ? FULL_S : raw_q);
  assign diff   = clampv - raw_q;

  // a clamped difference past this range saturates the integral all the same
  logic signed [RAW_W-1:0] dsat;
  always_comb begin
    priority if (raw_q > DMAX_S) dsat = DMAX_S;
    else if (raw_q < DMIN_S)     dsat = DMIN_S;
    else                         dsat = raw_q;
  end

  // integral write-back: floor(kw * diff / 2^16) added, then saturated
  logic signed [TS_W-1:0] tsum;
  logic signed [AW-1:0]   integ_d;
  assign tsum = {acc_q[PW-1], acc_q[PW-1:FR]} +
                {{(TS_W-AW){erri_q[AW-1]}}, erri_q};
  always_comb begin
    priority if (tsum > TMAX_S) integ_d = TMAX_S[AW-1:0];
    else if (tsum < TMIN_S)     integ_d = TMIN_S[AW-1:0];
    else                        integ_d = tsum[AW-1:0];
  end

  // control, configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      setpoint_q  <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      kw_q        <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      st_q        <= ST_IDLE;
      op_q        <= pidaw_pkg::OP_PROP;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pidaw_pkg::REG_ENABLE:      enable_q   <= cfg_data_i[0];
          pidaw_pkg::REG_SETPOINT:    setpoint_q <= cfg_data_i[SW-1:0];
          pidaw_pkg::REG_GAIN_PROP:   kp_q       <= cfg_data_i[GW-1:0];
          pidaw_pkg::REG_GAIN_INTEG:  ki_q       <= cfg_data_i[GW-1:0];
          pidaw_pkg::REG_GAIN_DERIV:  kd_q       <= cfg_data_i[GW-1:0];
          pidaw_pkg::REG_GAIN_WINDUP: kw_q       <= cfg_data_i[GW-1:0];
          default: ;
        endcase
      end

      // a new result may replace the one taken in the same cycle
      if (out_take || fin_done) out_valid_q <= fin_done;

      unique case (st_q)
        ST_IDLE: begin
          if (use_item) st_q <= ST_PREP;
        end
        ST_PREP: begin
          op_q  <= pidaw_pkg::OP_PROP;
          cnt_q <= CW'(NCH - 1);
          st_q  <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt_q == '0) begin
            st_q <= (op_q == pidaw_pkg::OP_WINDUP) ? ST_FIN : ST_ACC;
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        ST_ACC: begin
          cnt_q <= CW'(NCH - 1);
          if (op_q == pidaw_pkg::OP_DERIV) begin
            st_q <= ST_CLAMP;
          end else begin
            op_q <= op_q + 2'd1;
            st_q <= ST_MUL;
          end
        end
        ST_CLAMP: st_q <= ST_DSAT;
        ST_DSAT: begin
          op_q  <= pidaw_pkg::OP_WINDUP;
          cnt_q <= CW'(NCH - 1);
          st_q  <= ST_MUL;
        end
        ST_FIN: begin
          if (out_free) begin
            prev_err_q  <= err_q;
            integ_q     <= integ_d;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (use_item) begin
          err_q <= {setpoint_q[SW-1], setpoint_q} - {temperature_i[SW-1], temperature_i};
        end
      end
      ST_PREP: begin
        erri_q <= erri_d;
        errd_q <= {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
        x_q    <= {{(XEW-ERR_W){err_q[ERR_W-1]}}, err_q};
        raw_q  <= '0;
      end
      ST_MUL: acc_q <= acc_d;
      ST_ACC: begin
        raw_q <= raw_q + acc_q[RAW_W-1:0];
        if (op_q == pidaw_pkg::OP_PROP) begin
          x_q <= {{(XEW-AW){erri_q[AW-1]}}, erri_q};
        end else begin
          x_q <= {{(XEW-DER_W){errd_q[DER_W-1]}}, errd_q};
        end
      end
      ST_CLAMP: begin
        res_duty_q <= duty_d;
        res_sat_q  <= sat_d;
        raw_q      <= diff;
      end
      ST_DSAT: x_q <= {{(XEW-XW){dsat[XW-1]}}, dsat[XW-1:0]};
      ST_FIN: begin
        if (out_free) begin
          out_duty_q <= res_duty_q;
          out_sat_q  <= res_sat_q;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_item_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    use_item |=> (st_q == ST_PREP))
    else $error("used sample did not start the sequence");

  a_dropped_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !use_item) |=> (st_q == ST_IDLE))
    else $error("dropped sample left the block busy");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == ST_FIN))
    else $error("result appeared outside write-back");

  a_slice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL) |-> (cnt_q <= CW'(NCH - 1)))
    else $error("slice counter out of range");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q <= DUTY_FULL))
    else $error("duty above full scale");

endmodule

@@ tb/pid_antiwindup_controller_core_tb.sv @@
module pid_antiwindup_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = pidaw_pkg::SAMPLE_WIDTH_DEF;
  localparam int DATA_W      = (SAMPLE_W > pidaw_pkg::GAIN_W) ? SAMPLE_W : pidaw_pkg::GAIN_W;
  localparam int RAND_ITEMS  = 1400;
  localparam int SETTLE_CYC  = 32;
  localparam int HOLD_CYC    = 600;
  localparam int HOLD_AFTER  = 500;
  localparam int CYCLE_LIMIT = 1500000;

  // indexes past the register map; writes there must be ignored
  localparam logic [pidaw_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pidaw_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint ACC_MAX  = (64'sd1 <<< (pidaw_pkg::ACC_WIDTH_DEF - 1)) - 1;
  localparam longint ACC_MIN  = -ACC_MAX - 1;
  localparam longint FULL_Q16 = longint'(pidaw_pkg::DUTY_MAX) <<< pidaw_pkg::PROD_FRAC;
  localparam longint HALF_Q16 = 64'sd1 <<< (pidaw_pkg::PROD_FRAC - 1);

  typedef struct packed {
    logic [pidaw_pkg::DUTY_W-1:0] duty;
    logic                         sat;
  } duty_beat_t;

  typedef struct packed {
    logic [15:0] en;
    logic [15:0] sp;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [15:0] kw;
  } pid_cfg_t;

  typedef struct packed {
    logic [2:0]                   cfg;
    logic [15:0]                  temp;
    logic                         valid;
    logic                         typed;
    logic [pidaw_pkg::DUTY_W-1:0] duty;
    logic                         sat;
  } dir_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [pidaw_pkg::REG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]               cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic signed [SAMPLE_W-1:0]      temperature_i;
  logic                            sample_valid_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [pidaw_pkg::DUTY_W-1:0]    duty_o;
  logic                            saturated_o;

  pid_antiwindup_controller_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .temperature_i  (temperature_i),
    .sample_valid_i (sample_valid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_o         (duty_o),
    .saturated_o    (saturated_o)
  );

  // controller copy: registers and loop state
  bit     loop_en;
  longint setpoint, kp, ki, kd, kw;
  longint last_err, integ_acc;

  duty_beat_t duty_expect_q [$];
  int         err_cnt;
  int         results_seen;
  int         cycle_cnt;

  // expectation typed into the current directed row
  logic                         row_typed;
  logic [pidaw_pkg::DUTY_W-1:0] row_duty;
  logic                         row_sat;

  // cfg: 0 reset, 1 unit P gain, 2 and 3 gain extremes, 4 enable bit clear
  pid_cfg_t dir_cfg [5] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0001, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0001, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF},
    '{16'h0001, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000},
    '{16'hFFFE, 16'h1234, 16'h0100, 16'h0100, 16'h0100, 16'h0100}
  };

  dir_row_t dir_rows [23] = '{
    // loop stopped after reset
    '{3'd0, 16'h1234, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd0, 16'h8000, 1'b0, 1'b0, 7'd0,   1'b0},
    // kp = 1.0: duty reads straight off the error
    '{3'd1, 16'hCE00, 1'b1, 1'b1, 7'd50,  1'b0},
    '{3'd1, 16'h8000, 1'b1, 1'b1, 7'd100, 1'b1},
    '{3'd1, 16'h7FFF, 1'b1, 1'b1, 7'd0,   1'b1},
    '{3'd1, 16'hCE00, 1'b0, 1'b0, 7'd0,   1'b0},
    '{3'd1, 16'h0080, 1'b1, 1'b1, 7'd0,   1'b1},
    '{3'd1, 16'h0001, 1'b1, 1'b1, 7'd0,   1'b1},
    '{3'd1, 16'h9C81, 1'b1, 1'b1, 7'd99,  1'b0},
    '{3'd1, 16'h9C80, 1'b1, 1'b1, 7'd100, 1'b0},
    '{3'd1, 16'h9C40, 1'b1, 1'b1, 7'd100, 1'b0},
    '{3'd1, 16'h9C00, 1'b1, 1'b1, 7'd100, 1'b0},
    '{3'd1, 16'h9BFF, 1'b1, 1'b1, 7'd100, 1'b1},
    // windup drives the integral into its bounds
    '{3'd2, 16'h8000, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd2, 16'h8000, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd2, 16'h8000, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd2, 16'h7FFF, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd2, 16'h0000, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd3, 16'h7FFF, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd3, 16'h7FFF, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd3, 16'h7FFF, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd3, 16'h8000, 1'b1, 1'b0, 7'd0,   1'b0},
    '{3'd4, 16'h0000, 1'b1, 1'b0, 7'd0,   1'b0}
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clip_acc(longint x);
    if (x > ACC_MAX) return ACC_MAX;
    if (x < ACC_MIN) return ACC_MIN;
    return x;
  endfunction

  function automatic void set_reg(logic [pidaw_pkg::REG_IDX_W-1:0] idx,
                                  logic [DATA_W-1:0] data);
    case (idx)
      pidaw_pkg::REG_ENABLE:      loop_en  = data[0];
      pidaw_pkg::REG_SETPOINT:    setpoint = $signed(data[SAMPLE_W-1:0]);
      pidaw_pkg::REG_GAIN_PROP:   kp       = $signed(data[pidaw_pkg::GAIN_W-1:0]);
      pidaw_pkg::REG_GAIN_INTEG:  ki       = $signed(data[pidaw_pkg::GAIN_W-1:0]);
      pidaw_pkg::REG_GAIN_DERIV:  kd       = $signed(data[pidaw_pkg::GAIN_W-1:0]);
      pidaw_pkg::REG_GAIN_WINDUP: kw       = $signed(data[pidaw_pkg::GAIN_W-1:0]);
      default: ;
    endcase
  endfunction

  // one loop tick; returns 0 when the beat yields no duty
  function automatic bit next_duty(logic signed [SAMPLE_W-1:0] temp, logic usable,
                                   output duty_beat_t res);
    longint e, e_int, e_der, raw, rounded, clamped, diff, hi, lo, term;
    res = '0;
    if (!loop_en || !usable) return 1'b0;
    e       = setpoint - longint'(temp);
    e_int   = clip_acc(e + integ_acc);
    e_der   = e - last_err;
    raw     = kp * e + ki * e_int + kd * e_der;
    rounded = raw + HALF_Q16;
    if (rounded < 0)
      res.duty = '0;
    else if (rounded >= FULL_Q16)
      res.duty = pidaw_pkg::DUTY_W'(pidaw_pkg::DUTY_MAX);
    else
      res.duty = pidaw_pkg::DUTY_W'(rounded >>> pidaw_pkg::PROD_FRAC);
    res.sat = (raw < 0) || (raw > FULL_Q16);
    clamped = (raw < 0) ? 64'sd0 : ((raw > FULL_Q16) ? FULL_Q16 : raw);
    // split so that kw * diff cannot leave 64 bits; floor is exact
    diff = clamped - raw;
    hi   = diff >>> pidaw_pkg::PROD_FRAC;
    lo   = diff - (hi <<< pidaw_pkg::PROD_FRAC);
    term = kw * hi + ((kw * lo) >>> pidaw_pkg::PROD_FRAC);
    last_err  = e;
    integ_acc = clip_acc(e_int + term);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    duty_beat_t got, want, calc;
    bit         hit;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{duty_o, saturated_o};
        results_seen++;
        if (duty_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: expected no beat, got duty %0d saturated %0b",
                   $time, got.duty, got.sat);
        end else begin
          want = duty_expect_q.pop_front();
          if (got.duty !== want.duty) begin
            err_cnt++;
            $display("%0t: duty expected %0d got %0d", $time, want.duty, got.duty);
          end
          if (got.sat !== want.sat) begin
            err_cnt++;
            $display("%0t: saturated expected %0b got %0b", $time, want.sat, got.sat);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        hit = next_duty(temperature_i, sample_valid_i, calc);
        if (row_typed)
          duty_expect_q.push_back('{row_duty, row_sat});
        else if (hit)
          duty_expect_q.push_back(calc);
      end
    end
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    int  n;
    bit  held;
    held = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        n = HOLD_CYC;
      end else begin
        n = gap_cycles();
      end
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(50, 300)) @(negedge clk_i);
      else
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_beat(logic [15:0] temp, logic usable, logic typed,
                           logic [pidaw_pkg::DUTY_W-1:0] duty, logic sat, int gap);
    in_valid_i     = 1'b1;
    temperature_i  = temp;
    sample_valid_i = usable;
    row_typed      = typed;
    row_duty       = duty;
    row_sat        = sat;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (duty_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [pidaw_pkg::REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_config(pid_cfg_t c);
    wait_idle();
    write_reg(REG_SPARE_LO, DATA_W'($urandom));
    write_reg(pidaw_pkg::REG_SETPOINT, c.sp);
    write_reg(pidaw_pkg::REG_GAIN_PROP, c.kp);
    write_reg(pidaw_pkg::REG_GAIN_INTEG, c.ki);
    write_reg(pidaw_pkg::REG_GAIN_DERIV, c.kd);
    write_reg(pidaw_pkg::REG_GAIN_WINDUP, c.kw);
    write_reg(REG_SPARE_HI, DATA_W'($urandom));
    write_reg(pidaw_pkg::REG_ENABLE, c.en);
    cfg_we_i = 1'b0;
  endtask

  function automatic pid_cfg_t rand_cfg();
    pid_cfg_t    c;
    int          mode;
    logic [15:0] pick [4];
    pick = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0100};
    mode = $urandom_range(0, 9);
    c.en = 16'($urandom) | 16'h0001;
    if (mode == 0) begin
      c = pid_cfg_t'({$urandom, $urandom, $urandom});
    end else if (mode == 1) begin
      c.sp = pick[$urandom_range(0, 1)];
      c.kp = pick[$urandom_range(0, 3)];
      c.ki = pick[$urandom_range(0, 3)];
      c.kd = pick[$urandom_range(0, 3)];
      c.kw = pick[$urandom_range(0, 3)];
    end else begin
      // plausible tuning: 10..100 degC target, modest gains
      c.sp = 16'($urandom_range(2560, 25600));
      c.kp = 16'($urandom_range(0, 3072));
      c.ki = 16'($urandom_range(0, 128));
      c.kd = 16'($urandom_range(0, 1024));
      c.kw = 16'($urandom_range(0, 1024));
    end
    return c;
  endfunction

  initial begin
    pid_cfg_t    c;
    logic [2:0]  cur_cfg;
    logic [15:0] t;
    logic        v;
    int          sent, n;
    bit          no_gaps;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = pidaw_pkg::REG_ENABLE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    temperature_i  = '0;
    sample_valid_i = 1'b0;
    row_typed      = 1'b0;
    row_duty       = '0;
    row_sat        = 1'b0;
    loop_en        = 1'b0;
    setpoint       = 0;
    kp             = 0;
    ki             = 0;
    kd             = 0;
    kw             = 0;
    last_err       = 0;
    integ_acc      = 0;
    err_cnt        = 0;
    results_seen   = 0;
    cycle_cnt      = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    cur_cfg = 3'd0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cur_cfg) begin
        cur_cfg = dir_rows[i].cfg;
        apply_config(dir_cfg[cur_cfg]);
      end
      send_beat(dir_rows[i].temp, dir_rows[i].valid, dir_rows[i].typed,
                dir_rows[i].duty, dir_rows[i].sat, gap_cycles());
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      c = rand_cfg();
      apply_config(c);
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 150);
      if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
      repeat (n) begin
        if ($urandom_range(0, 4) == 0)
          t = 16'($urandom);
        else
          t = 16'($signed(c.sp) + int'($urandom_range(0, 4096)) - 2048);
        v = ($urandom_range(0, 9) != 0);
        sent++;
        send_beat(t, v, 1'b0, '0, 1'b0, no_gaps ? 0 : gap_cycles());
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
